[hw/rtl/ddm_pkg.sv]
// decimal digit multiplier: shared types, codes and constants
// no dependencies; used by decimal_digit_multiplier_core and ddm_digit_mac

package ddm_pkg;

	localparam int DIGIT_W = 4;
	localparam int LIMIT_W = 7;
	localparam int APB_DW = 32;
	localparam int APB_AW = 2;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
	localparam logic [6:0] RADIX = 7'd10;
	localparam logic [7:0] DIV10_MUL = 8'd205;
	localparam int DIV10_SHIFT = 11;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic [APB_AW-1:0] ADDR_DIGIT_LIMIT = 2'd0;

	localparam logic OP_MULTIPLICAND = 1'b0;
	localparam logic OP_MULTIPLIER = 1'b1;

	typedef struct packed {
		logic operation;
		logic [DIGIT_W-1:0] digit;
		logic last;
	} ddm_in_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] product_digit;
		logic last_res;
		logic error;
	} ddm_out_t;

	typedef struct packed {
		logic step;
		logic clear;
		logic acc_zero;
	} ddm_mac_ctl_t;

	// t below 100: quotient by reciprocal multiply, remainder by one subtract
	function automatic logic [7:0] div10(input logic [6:0] t);
		logic [14:0] p;
		logic [3:0] q;
		logic [6:0] r;
		p = {8'd0, t} * {7'd0, DIV10_MUL};
		q = p[14:DIV10_SHIFT];
		r = t - 7'({3'd0, q} * RADIX);
		return {q, r[3:0]};
	endfunction

endpackage

[hw/rtl/decimal_digit_multiplier_core.sv]
// decimal digit multiplier top level: operand loading, multiply sequencer, product output
// depends on ddm_pkg, ddm_ram, ddm_digit_mac
//
// usage:
// operand channel (operand_valid/operand_ready/operand) takes one digit per beat,
// least significant first: multiplicand digits, then multiplier digits; the
// multiplier beat with last set starts the multiply. product channel gives
// X_len+Y_len digit beats, least significant first, last_res on the final one,
// or one error beat (digit 0, last_res 1, error 1) if the multiplicand is empty
// or X_len+Y_len reaches min(digit_limit, MAX_DIGITS).
// the multiply runs through a single digit mac fed from registered-read rams:
// a read and a write state per digit pair, a carry state per multiplicand
// digit; then each product digit takes an accumulator read and an output load.
// the operand channel is ready only while no run is in progress and no error
// beat waits to load; the last product beat may still wait in the output
// register while new digits load. a stalled receiver holds the sequencer
// until the output register frees. reset empties both operands, clears the
// output valid flag and sets digit_limit to 64; no ram clearing pass is needed.
// digit_limit is written over the apb port at byte address 0.

module decimal_digit_multiplier_core
	import ddm_pkg::*;
#(
	parameter int MAX_DIGITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              operand_valid,
	output logic              operand_ready,
	input  ddm_in_t           operand,
	output logic              product_valid,
	input  logic              product_ready,
	output ddm_out_t          product,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int TW = CW + 1;
	localparam int CMPW = TW + LIMIT_W;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_MUL_RD  = 6'b000010,
		ST_MUL_WR  = 6'b000100,
		ST_CARRY   = 6'b001000,
		ST_EMIT_RD = 6'b010000,
		ST_EMIT_WR = 6'b100000
	} state_t;

	localparam logic [5:0] ST_ERR_CODE = 6'b000000;

	state_t state_q;
	logic err_pend_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0] xcnt_q;
	logic [CW-1:0] ycnt_q;
	logic [AW-1:0] xlast_q;
	logic [AW-1:0] ylast_q;
	logic [AW-1:0] klast_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] k_q;
	logic product_valid_q;
	ddm_out_t product_q;

	logic in_beat;
	logic out_free;
	logic out_load;
	ddm_out_t out_next;
	logic [DIGIT_W-1:0] digit_sat;
	logic x_room;
	logic y_room;
	logic x_we;
	logic y_we;
	logic start;
	logic [CW-1:0] yl_next;
	logic [TW-1:0] total_next;
	logic [CMPW-1:0] lim_ext;
	logic [CMPW-1:0] max_ext;
	logic [CMPW-1:0] lim_eff;
	logic run_err;

	logic [AW-1:0] x_raddr;
	logic [AW-1:0] y_raddr;
	logic [AW-1:0] acc_raddr;
	logic [AW-1:0] acc_waddr;
	logic [DIGIT_W-1:0] acc_wdata;
	logic acc_we;
	logic [DIGIT_W-1:0] x_rdata;
	logic [DIGIT_W-1:0] y_rdata;
	logic [DIGIT_W-1:0] acc_rdata;
	logic [DIGIT_W-1:0] mac_sum;
	logic [DIGIT_W-1:0] mac_carry;
	ddm_mac_ctl_t mac_ctl;

	// apb register
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_DIGIT_LIMIT) ? APB_DW'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// operand loading and run decision
	assign operand_ready = (state_q == ST_IDLE) && !err_pend_q;
	assign in_beat = operand_valid && operand_ready;
	assign digit_sat = (operand.digit > DIGIT_MAX) ? DIGIT_MAX : operand.digit;
	assign x_room = xcnt_q < CW'(MAX_DIGITS);
	assign y_room = ycnt_q < CW'(MAX_DIGITS);
	assign x_we = in_beat && (operand.operation == OP_MULTIPLICAND) && x_room;
	assign y_we = in_beat && (operand.operation == OP_MULTIPLIER) && y_room;
	assign start = in_beat && (operand.operation == OP_MULTIPLIER) && operand.last;
	assign yl_next = ycnt_q + CW'(y_room);
	assign total_next = TW'(xcnt_q) + TW'(yl_next);
	assign lim_ext = CMPW'(limit_q);
	assign max_ext = CMPW'(MAX_DIGITS);
	assign lim_eff = (lim_ext > max_ext) ? max_ext : lim_ext;
	assign run_err = (xcnt_q == '0) || (CMPW'(total_next) >= lim_eff);

	// output register
	assign out_free = !product_valid_q || product_ready;
	assign product_valid = product_valid_q;
	assign product = product_q;

	always_comb begin
		out_load = 1'b0;
		out_next = '0;
		if (state_q == ST_EMIT_WR) begin
			out_load = 1'b1;
			out_next.product_digit = acc_rdata;
			out_next.last_res = (k_q == klast_q);
			out_next.error = 1'b0;
		end else if (err_pend_q && out_free) begin
			out_load = 1'b1;
			out_next.product_digit = '0;
			out_next.last_res = 1'b1;
			out_next.error = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_valid_q <= 1'b0;
		end else if (out_load) begin
			product_valid_q <= 1'b1;
		end else if (product_ready) begin
			product_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			product_q <= out_next;
		end
	end

	// ram addressing and mac control
	assign x_raddr = i_q;
	assign y_raddr = j_q;
	assign acc_raddr = (state_q == ST_EMIT_RD) ? k_q : AW'(i_q + j_q);

	always_comb begin
		acc_we = 1'b0;
		acc_waddr = AW'(i_q + j_q);
		acc_wdata = mac_sum;
		mac_ctl = '0;
		mac_ctl.acc_zero = (i_q == '0);
		mac_ctl.clear = start;
		case (state_q)
			ST_MUL_WR: begin
				acc_we = 1'b1;
				mac_ctl.step = 1'b1;
			end
			ST_CARRY: begin
				acc_we = 1'b1;
				acc_waddr = AW'(i_q + ylast_q + AW'(1));
				acc_wdata = mac_carry;
				mac_ctl.clear = 1'b1;
			end
			default: begin
				acc_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			err_pend_q <= 1'b0;
			xcnt_q <= '0;
			ycnt_q <= '0;
			xlast_q <= '0;
			ylast_q <= '0;
			klast_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (err_pend_q && out_free) begin
				err_pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (x_we) begin
						xcnt_q <= xcnt_q + CW'(1);
					end
					if (y_we) begin
						ycnt_q <= ycnt_q + CW'(1);
					end
					if (start) begin
						xcnt_q <= '0;
						ycnt_q <= '0;
						xlast_q <= AW'(xcnt_q - CW'(1));
						ylast_q <= AW'(yl_next - CW'(1));
						klast_q <= AW'(total_next - TW'(1));
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						if (run_err) begin
							err_pend_q <= 1'b1;
						end else begin
							state_q <= ST_MUL_RD;
						end
					end
				end
				ST_MUL_RD: begin
					state_q <= ST_MUL_WR;
				end
				ST_MUL_WR: begin
					if (j_q == ylast_q) begin
						state_q <= ST_CARRY;
					end else begin
						j_q <= j_q + AW'(1);
						state_q <= ST_MUL_RD;
					end
				end
				ST_CARRY: begin
					j_q <= '0;
					if (i_q == xlast_q) begin
						k_q <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= ST_MUL_RD;
					end
				end
				ST_EMIT_RD: begin
					if (out_free) begin
						state_q <= ST_EMIT_WR;
					end
				end
				ST_EMIT_WR: begin
					if (k_q == klast_q) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + AW'(1);
						state_q <= ST_EMIT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ddm_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_x_ram (
		.clk  (clk),
		.we   (x_we),
		.waddr(xcnt_q[AW-1:0]),
		.wdata(digit_sat),
		.raddr(x_raddr),
		.rdata(x_rdata)
	);

	ddm_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_y_ram (
		.clk  (clk),
		.we   (y_we),
		.waddr(ycnt_q[AW-1:0]),
		.wdata(digit_sat),
		.raddr(y_raddr),
		.rdata(y_rdata)
	);

	ddm_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(MAX_DIGITS)
	) u_acc_ram (
		.clk  (clk),
		.we   (acc_we),
		.waddr(acc_waddr),
		.wdata(acc_wdata),
		.raddr(acc_raddr),
		.rdata(acc_rdata)
	);

	ddm_digit_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.acc_digit(acc_rdata),
		.x_digit  (x_rdata),
		.y_digit  (y_rdata),
		.sum_digit(mac_sum),
		.carry    (mac_carry)
	);

	// assertions
	a_mul_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_WR) |-> ((i_q <= xlast_q) && (j_q <= ylast_q)))
		else $error("multiply index beyond operand length");

	a_carry_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_carry <= DIGIT_MAX))
		else $error("mac carry above nine");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT_WR) || (err_pend_q && state_q != ST_IDLE)) |->
		(state_q == ST_EMIT_WR ? !product_valid_q : 1'b0))
		else $error("product loaded over a waiting beat or error pending mid-run");

	a_error_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(product_valid_q && product_q.error) |->
		(product_q.last_res && (product_q.product_digit == '0)))
		else $error("error beat not final or nonzero");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_ERR_CODE))
		else $error("sequencer state lost");

endmodule

[hw/rtl/ddm_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies

module ddm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/ddm_digit_mac.sv]
// one decimal digit multiply-accumulate step with carry register
// depends on ddm_pkg

module ddm_digit_mac
	import ddm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ddm_mac_ctl_t       ctl,
	input  logic [DIGIT_W-1:0] acc_digit,
	input  logic [DIGIT_W-1:0] x_digit,
	input  logic [DIGIT_W-1:0] y_digit,
	output logic [DIGIT_W-1:0] sum_digit,
	output logic [DIGIT_W-1:0] carry
);

	logic [DIGIT_W-1:0] carry_q;
	logic [DIGIT_W-1:0] acc_eff;
	logic [7:0] prod;
	logic [6:0] t;
	logic [7:0] qr;

	assign acc_eff = ctl.acc_zero ? '0 : acc_digit;
	assign prod = {4'd0, x_digit} * {4'd0, y_digit};
	assign t = {3'd0, acc_eff} + prod[6:0] + {3'd0, carry_q};
	assign qr = div10(t);
	assign sum_digit = qr[3:0];
	assign carry = carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (ctl.clear) begin
			carry_q <= '0;
		end else if (ctl.step) begin
			carry_q <= qr[7:4];
		end
	end

endmodule
